// File: rtl/core/seeded_region_fill_boundary_macros.svh
// assertion helpers for the region fill block
`ifndef SEEDED_REGION_FILL_BOUNDARY_MACROS_SVH
`define SEEDED_REGION_FILL_BOUNDARY_MACROS_SVH

// same-cycle implication, checked outside reset
`define SRFB_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("region fill check failed");

// next-cycle implication, checked outside reset
`define SRFB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("region fill check failed");

`endif

// File: rtl/core/srfb_pkg.sv
`default_nettype none
package srfb_pkg;

    localparam int DEF_MAX_ROWS   = 64;
    localparam int DEF_MAX_COLS   = 64;
    localparam int DEF_PIXEL_BITS = 8;

    localparam int DIM_RESET = 64;

    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_FILL  = 2'd1,
        ACT_READ  = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        CFG_CONN = 2'd0,
        CFG_ROWS = 2'd1,
        CFG_COLS = 2'd2
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLR,
        S_SEED_RD,
        S_SEED_WT,
        S_POP,
        S_POP_WT,
        S_NB,
        S_NB_WT,
        S_FILL_OUT,
        S_RD_CTR,
        S_RD_CTR_WT,
        S_RD_NB,
        S_RD_NB_WT,
        S_RD_OUT
    } t_state;

    // neighbour row offsets, first four are the 4-neighbourhood
    function automatic logic signed [1:0] nb_dr(input logic [2:0] k);
        logic signed [1:0] d;
        case (k)
            3'd0: d = 2'sd1;
            3'd1: d = -2'sd1;
            3'd2: d = 2'sd0;
            3'd3: d = 2'sd0;
            3'd4: d = -2'sd1;
            3'd5: d = 2'sd1;
            3'd6: d = 2'sd1;
            default: d = -2'sd1;
        endcase
        return d;
    endfunction

    function automatic logic signed [1:0] nb_dc(input logic [2:0] k);
        logic signed [1:0] d;
        case (k)
            3'd0: d = 2'sd0;
            3'd1: d = 2'sd0;
            3'd2: d = 2'sd1;
            3'd3: d = -2'sd1;
            3'd4: d = 2'sd1;
            3'd5: d = 2'sd1;
            3'd6: d = -2'sd1;
            default: d = -2'sd1;
        endcase
        return d;
    endfunction

    function automatic int clamp_dim(input int v, input int maxv);
        int r;
        if (v == 0) begin
            r = 1;
        end else if (v > maxv) begin
            r = maxv;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/srfb_ram.sv
`default_nettype none
module srfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// File: rtl/core/srfb_nbr.sv
`default_nettype none
module srfb_nbr
    import srfb_pkg::*;
#(
    parameter int RW = 6,
    parameter int CW = 6
) (
    input  wire logic [RW-1:0] i_r,
    input  wire logic [CW-1:0] i_c,
    input  wire logic [2:0]    i_k,
    input  wire logic [RW:0]   i_lim_r,
    input  wire logic [CW:0]   i_lim_c,
    output logic      [RW-1:0] o_r,
    output logic      [CW-1:0] o_c,
    output logic               o_ok
);

    logic signed [RW+1:0] s_r;
    logic signed [CW+1:0] s_c;

    // offset add plus bounds compare, shared by fill and read
    always_comb begin
        s_r  = $signed({2'b00, i_r}) + (RW+2)'(nb_dr(i_k));
        s_c  = $signed({2'b00, i_c}) + (CW+2)'(nb_dc(i_k));
        o_ok = !s_r[RW+1] && !s_c[CW+1] && (s_r[RW:0] < i_lim_r) && (s_c[CW:0] < i_lim_c);
        o_r  = s_r[RW-1:0];
        o_c  = s_c[CW-1:0];
    end

endmodule
`default_nettype wire

// File: rtl/core/seeded_region_fill_boundary.sv
`default_nettype none
// seeded region fill with boundary extraction
// command channel: start is taken when busy is low; action write stores one
// pixel in the accept cycle and gives no result, fill and read run a sequence
// and present one result on the output ports for one cycle with o_valid high.
// config: i_cfg_we/i_cfg_idx/i_cfg_data write connectivity, rows, columns;
// only write while busy is low.
// fill sequence: a clearing pass over the visited map, the seed lookup,
// then for each region pixel a pop and a lookup of each of its N
// neighbours, N being 4 or 8 (a neighbour outside the area in use skips
// the lookup wait), then a final pop on the empty stack and the output
// state; every step goes through one neighbour unit and the registered
// read ports of the image, visited and stack memories.
// read sequence: outside the box straight to the output state, else the
// center lookup and, for a center in the region, eight neighbour lookups
// through the same unit.
// write: stored in the accept cycle, no result; one transaction at a time.
// reset: after i_rst_n is released the visited map is cleared in one pass
// with busy high; box and count registers start at zero.
// the receiver cannot stall; each result transaction lasts exactly one cycle.
module seeded_region_fill_boundary
    import srfb_pkg::*;
#(
    parameter int MAX_ROWS   = DEF_MAX_ROWS,
    parameter int MAX_COLS   = DEF_MAX_COLS,
    parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_action,
    input  wire logic [5:0]  i_row,
    input  wire logic [5:0]  i_col,
    input  wire logic [7:0]  i_pixel,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [6:0]  i_cfg_data,
    output logic             o_valid,
    output logic [5:0]       o_box_top,
    output logic [5:0]       o_box_left,
    output logic [6:0]       o_box_height,
    output logic [6:0]       o_box_width,
    output logic [12:0]      o_region_size,
    output logic [7:0]       o_region_value,
    output logic [7:0]       o_boundary_value,
    output logic             o_in_region,
    output logic             o_on_boundary
);

    localparam int RW     = $clog2(MAX_ROWS);
    localparam int CW     = $clog2(MAX_COLS);
    localparam int AW     = RW + CW;
    localparam int DEPTH  = 2 ** AW;
    localparam int CELLS  = MAX_ROWS * MAX_COLS;
    localparam int SDW    = $clog2(CELLS + 1);

    // config registers
    logic            r_conn;
    logic [6:0]      r_rows, r_cols;
    logic [RW:0]     s_nr;
    logic [CW:0]     s_nc;

    // sequencer
    t_state          r_state, n_state;
    logic [AW-1:0]   r_clr_addr;
    logic            r_fill_pend;
    logic [5:0]      r_in_r, r_in_c;
    logic [PIXEL_BITS-1:0] r_target, r_fill_val;
    logic [RW-1:0]   r_cur_r, r_j_r, r_minr, r_maxr, r_box_top;
    logic [CW-1:0]   r_cur_c, r_j_c, r_minc, r_maxc, r_box_left;
    logic [RW:0]     r_box_h;
    logic [CW:0]     r_box_w;
    logic [2:0]      r_k;
    logic [SDW-1:0]  r_depth, r_count, r_total;
    logic            r_hit, r_edge;

    // memories
    logic [PIXEL_BITS-1:0] s_img_rdata;
    logic                  s_vis_rdata;
    logic [AW-1:0]         s_stk_rdata;
    logic [AW-1:0]         s_look_addr;
    logic                  s_vis_we, s_vis_wdata, s_stk_we, s_img_we;
    logic [AW-1:0]         s_vis_waddr, s_stk_waddr, s_stk_raddr, s_img_waddr;

    // neighbour unit
    logic            s_rd_mode;
    logic [RW:0]     s_lim_r;
    logic [CW:0]     s_lim_c;
    logic [RW-1:0]   s_nb_r;
    logic [CW-1:0]   s_nb_c;
    logic            s_nb_ok;
    logic [2:0]      s_k_last;
    logic            s_accept, s_seed_in, s_rd_in, s_push;

    assign busy     = (r_state != S_IDLE);
    assign s_accept = start && !busy;
    assign s_nr     = (RW+1)'(clamp_dim(int'(r_rows), MAX_ROWS));
    assign s_nc     = (CW+1)'(clamp_dim(int'(r_cols), MAX_COLS));
    assign s_k_last = r_conn ? 3'd7 : 3'd3;
    assign s_seed_in = (int'(r_in_r) < int'(s_nr)) && (int'(r_in_c) < int'(s_nc));
    assign s_rd_in  = (r_total != '0) && (int'(i_row) < int'(r_box_h))
                   && (int'(i_col) < int'(r_box_w));
    // region match for the looked-up neighbour
    assign s_push   = !s_vis_rdata && (s_img_rdata == r_target);

    assign s_rd_mode = (r_state == S_RD_NB) || (r_state == S_RD_NB_WT);
    // fill bounds are the rows/cols in use, boundary reads use the whole store
    assign s_lim_r  = s_rd_mode ? (RW+1)'(MAX_ROWS) : s_nr;
    assign s_lim_c  = s_rd_mode ? (CW+1)'(MAX_COLS) : s_nc;

    srfb_nbr #(.RW(RW), .CW(CW)) u_nbr (
        .i_r     (r_cur_r),
        .i_c     (r_cur_c),
        .i_k     (r_k),
        .i_lim_r (s_lim_r),
        .i_lim_c (s_lim_c),
        .o_r     (s_nb_r),
        .o_c     (s_nb_c),
        .o_ok    (s_nb_ok)
    );

    // pixel writes go straight in during the accept cycle
    assign s_img_we    = s_accept && (i_action == ACT_WRITE)
                      && (int'(i_row) < MAX_ROWS) && (int'(i_col) < MAX_COLS);
    assign s_img_waddr = {RW'(i_row), CW'(i_col)};
    assign s_stk_raddr = AW'(r_depth - SDW'(1));

    srfb_ram #(.WIDTH(PIXEL_BITS), .DEPTH(DEPTH)) u_img (
        .i_clk   (i_clk),
        .i_we    (s_img_we),
        .i_waddr (s_img_waddr),
        .i_wdata (PIXEL_BITS'(i_pixel)),
        .i_raddr (s_look_addr),
        .o_rdata (s_img_rdata)
    );

    srfb_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_vis (
        .i_clk   (i_clk),
        .i_we    (s_vis_we),
        .i_waddr (s_vis_waddr),
        .i_wdata (s_vis_wdata),
        .i_raddr (s_look_addr),
        .o_rdata (s_vis_rdata)
    );

    srfb_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_stk (
        .i_clk   (i_clk),
        .i_we    (s_stk_we),
        .i_waddr (s_stk_waddr),
        .i_wdata ({r_j_r, r_j_c}),
        .i_raddr (s_stk_raddr),
        .o_rdata (s_stk_rdata)
    );

    // config port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_conn <= 1'b0;
            r_rows <= 7'(DIM_RESET);
            r_cols <= 7'(DIM_RESET);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CONN: r_conn <= i_cfg_data[0];
                CFG_ROWS: r_rows <= i_cfg_data;
                CFG_COLS: r_cols <= i_cfg_data;
                default:  ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (s_accept && i_action == ACT_FILL) begin
                    n_state = S_CLR;
                end else if (s_accept && i_action == ACT_READ) begin
                    n_state = s_rd_in ? S_RD_CTR : S_RD_OUT;
                end
            end
            S_CLR: begin
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    if (!r_fill_pend) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = s_seed_in ? S_SEED_RD : S_FILL_OUT;
                    end
                end
            end
            S_SEED_RD:   n_state = S_SEED_WT;
            S_SEED_WT:   n_state = S_POP;
            S_POP:       n_state = (r_depth == '0) ? S_FILL_OUT : S_POP_WT;
            S_POP_WT:    n_state = S_NB;
            S_NB: begin
                if (s_nb_ok) begin
                    n_state = S_NB_WT;
                end else if (r_k == s_k_last) begin
                    n_state = S_POP;
                end
            end
            S_NB_WT:     n_state = (r_k == s_k_last) ? S_POP : S_NB;
            S_FILL_OUT:  n_state = S_IDLE;
            S_RD_CTR:    n_state = S_RD_CTR_WT;
            S_RD_CTR_WT: n_state = s_vis_rdata ? S_RD_NB : S_RD_OUT;
            S_RD_NB: begin
                if (s_nb_ok) begin
                    n_state = S_RD_NB_WT;
                end else if (r_k == 3'd7) begin
                    n_state = S_RD_OUT;
                end
            end
            S_RD_NB_WT:  n_state = (r_k == 3'd7) ? S_RD_OUT : S_RD_NB;
            S_RD_OUT:    n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // memory controls
    always_comb begin
        s_look_addr = {r_cur_r, r_cur_c};
        s_vis_we    = 1'b0;
        s_vis_waddr = {r_j_r, r_j_c};
        s_vis_wdata = 1'b1;
        s_stk_we    = 1'b0;
        s_stk_waddr = AW'(r_depth);
        unique case (r_state)
            S_CLR: begin
                s_vis_we    = 1'b1;
                s_vis_waddr = r_clr_addr;
                s_vis_wdata = 1'b0;
            end
            S_SEED_RD:  s_look_addr = {RW'(r_in_r), CW'(r_in_c)};
            S_SEED_WT: begin
                s_vis_we    = 1'b1;
                s_stk_we    = 1'b1;
                s_stk_waddr = '0;
            end
            S_NB, S_RD_NB: s_look_addr = {s_nb_r, s_nb_c};
            S_NB_WT: begin
                s_vis_we = s_push;
                s_stk_we = s_push;
            end
            default: ;
        endcase
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr_addr  <= '0;
            r_fill_pend <= 1'b0;
            r_depth     <= '0;
            r_total     <= '0;
            r_box_top   <= '0;
            r_box_left  <= '0;
            r_box_h     <= '0;
            r_box_w     <= '0;
            r_fill_val  <= '0;
            o_valid     <= 1'b0;
        end else begin
            r_state <= n_state;
            o_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    r_in_r   <= i_row;
                    r_in_c   <= i_col;
                    r_hit    <= 1'b0;
                    r_edge   <= 1'b0;
                    r_k      <= '0;
                    r_cur_r  <= RW'(int'(r_box_top) + int'(i_row));
                    r_cur_c  <= CW'(int'(r_box_left) + int'(i_col));
                    r_clr_addr  <= '0;
                    r_fill_pend <= 1'b1;
                end
                S_CLR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (r_clr_addr == AW'(DEPTH - 1)) begin
                        r_box_top  <= '0;
                        r_box_left <= '0;
                        r_box_h    <= '0;
                        r_box_w    <= '0;
                        r_total    <= '0;
                        r_fill_val <= '0;
                        r_j_r      <= RW'(r_in_r);
                        r_j_c      <= CW'(r_in_c);
                    end
                end
                S_SEED_WT: begin
                    r_target   <= s_img_rdata;
                    r_fill_val <= s_img_rdata;
                    r_depth    <= SDW'(1);
                    r_count    <= '0;
                    r_minr     <= r_j_r;
                    r_maxr     <= r_j_r;
                    r_minc     <= r_j_c;
                    r_maxc     <= r_j_c;
                end
                S_POP: begin
                    if (r_depth == '0) begin
                        r_box_top  <= r_minr;
                        r_box_left <= r_minc;
                        r_box_h    <= {1'b0, r_maxr - r_minr} + (RW+1)'(1);
                        r_box_w    <= {1'b0, r_maxc - r_minc} + (CW+1)'(1);
                        r_total    <= r_count;
                    end else begin
                        r_depth <= r_depth - SDW'(1);
                    end
                end
                S_POP_WT: begin
                    r_cur_r <= s_stk_rdata[AW-1:CW];
                    r_cur_c <= s_stk_rdata[CW-1:0];
                    r_count <= r_count + SDW'(1);
                    r_k     <= '0;
                    if (s_stk_rdata[AW-1:CW] < r_minr) r_minr <= s_stk_rdata[AW-1:CW];
                    if (s_stk_rdata[AW-1:CW] > r_maxr) r_maxr <= s_stk_rdata[AW-1:CW];
                    if (s_stk_rdata[CW-1:0] < r_minc)  r_minc <= s_stk_rdata[CW-1:0];
                    if (s_stk_rdata[CW-1:0] > r_maxc)  r_maxc <= s_stk_rdata[CW-1:0];
                end
                S_NB: begin
                    r_j_r <= s_nb_r;
                    r_j_c <= s_nb_c;
                    if (!s_nb_ok) begin
                        r_k <= r_k + 3'd1;
                    end
                end
                S_NB_WT: begin
                    r_k <= r_k + 3'd1;
                    if (s_push) begin
                        r_depth <= r_depth + SDW'(1);
                    end
                end
                S_FILL_OUT: begin
                    o_valid          <= 1'b1;
                    o_box_top        <= 6'(r_box_top);
                    o_box_left       <= 6'(r_box_left);
                    o_box_height     <= 7'(r_box_h);
                    o_box_width      <= 7'(r_box_w);
                    o_region_size    <= 13'(r_total);
                    o_region_value   <= '0;
                    o_boundary_value <= '0;
                    o_in_region      <= 1'b0;
                    o_on_boundary    <= 1'b0;
                end
                S_RD_CTR_WT: begin
                    r_hit <= s_vis_rdata;
                    r_k   <= '0;
                end
                S_RD_NB: begin
                    if (!s_nb_ok) begin
                        r_edge <= 1'b1;
                        r_k    <= r_k + 3'd1;
                    end
                end
                S_RD_NB_WT: begin
                    r_k <= r_k + 3'd1;
                    if (!s_vis_rdata) begin
                        r_edge <= 1'b1;
                    end
                end
                S_RD_OUT: begin
                    o_valid          <= 1'b1;
                    o_box_top        <= '0;
                    o_box_left       <= '0;
                    o_box_height     <= '0;
                    o_box_width      <= '0;
                    o_region_size    <= '0;
                    o_region_value   <= r_hit ? 8'(r_fill_val) : 8'd0;
                    o_boundary_value <= (r_hit && r_edge) ? 8'(r_fill_val) : 8'd0;
                    o_in_region      <= r_hit;
                    o_on_boundary    <= r_hit && r_edge;
                end
                default: ;
            endcase
        end
    end

`include "seeded_region_fill_boundary_macros.svh"

    // a boundary pixel is always a region pixel
    `SRFB_ASSERT_NOW(a_bnd_in_region, i_clk, i_rst_n, o_valid && o_on_boundary, o_in_region)
    // a read transaction never carries fill fields
    `SRFB_ASSERT_NOW(a_read_no_box, i_clk, i_rst_n, o_valid && o_in_region, o_region_size == '0)
    // a pixel write leaves the block ready
    `SRFB_ASSERT_NEXT(a_write_one_cycle, i_clk, i_rst_n,
        s_accept && i_action == ACT_WRITE, !busy)
    // the stack never outgrows the image
    `SRFB_ASSERT_NOW(a_stack_bound, i_clk, i_rst_n, 1'b1, int'(r_depth) <= CELLS)

endmodule
`default_nettype wire

// File: verif/tb_seeded_region_fill_boundary.sv
`default_nettype none
module tb_seeded_region_fill_boundary;
    import srfb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int GRID = 64;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int SETTLE_CYCLES = 60;
    // index past the register list, the block ignores it
    localparam logic [1:0] CFG_UNUSED = 2'd3;
    // action code with no meaning, the block ignores it
    localparam logic [1:0] ACT_NONE = 2'd3;

    typedef struct {
        logic [5:0]  box_top;
        logic [5:0]  box_left;
        logic [6:0]  box_height;
        logic [6:0]  box_width;
        logic [12:0] region_size;
        logic [7:0]  region_value;
        logic [7:0]  boundary_value;
        logic        in_region;
        logic        on_boundary;
    } region_result_t;

    // predicts the fill and read results and checks what the block returns
    class region_scoreboard;
        logic [7:0]     image[GRID*GRID];
        bit             visited[GRID*GRID];
        int             top, left, height, width, total;
        logic [7:0]     fill_val;
        bit             conn;
        int             rows_reg, cols_reg;
        region_result_t pending[$];
        int             errors;
        int             dr[8] = '{1, -1, 0, 0, -1, 1, 1, -1};
        int             dc[8] = '{0, 0, 1, -1, 1, 1, -1, -1};

        function new();
            rows_reg = GRID;
            cols_reg = GRID;
        endfunction

        function int eff_dim(int v);
            if (v == 0) return 1;
            if (v > GRID) return GRID;
            return v;
        endfunction

        function void set_reg(logic [1:0] idx, logic [6:0] d);
            case (idx)
                CFG_CONN: conn = d[0];
                CFG_ROWS: rows_reg = int'(d);
                CFG_COLS: cols_reg = int'(d);
                default: ;
            endcase
        endfunction

        function bit seen(int r, int c);
            if (r < 0 || c < 0 || r >= GRID || c >= GRID) return 1'b0;
            return visited[r*GRID + c];
        endfunction

        // grow the region from the seed with an explicit stack
        function void grow(int sr, int sc);
            int nr, nc, nbs, idx, r, c, r2, c2, j, maxr, maxc;
            int stack[$];
            nr = eff_dim(rows_reg);
            nc = eff_dim(cols_reg);
            nbs = conn ? 8 : 4;
            foreach (visited[i]) visited[i] = 1'b0;
            top = 0; left = 0; height = 0; width = 0; total = 0;
            fill_val = '0;
            if (sr >= nr || sc >= nc) return;
            fill_val = image[sr*GRID + sc];
            top = sr; maxr = sr; left = sc; maxc = sc;
            visited[sr*GRID + sc] = 1'b1;
            stack = {stack, sr*GRID + sc};
            while (stack.size() > 0) begin
                idx = stack.pop_back();
                r = idx / GRID;
                c = idx % GRID;
                total++;
                if (r < top) top = r;
                if (r > maxr) maxr = r;
                if (c < left) left = c;
                if (c > maxc) maxc = c;
                for (int k = 0; k < nbs; k++) begin
                    r2 = r + dr[k];
                    c2 = c + dc[k];
                    if (r2 < 0 || c2 < 0 || r2 >= nr || c2 >= nc) continue;
                    j = r2*GRID + c2;
                    if (visited[j] || image[j] != fill_val) continue;
                    visited[j] = 1'b1;
                    stack = {stack, j};
                end
            end
            height = maxr - top + 1;
            width = maxc - left + 1;
        endfunction

        // called for every accepted command transaction
        function void note(logic [1:0] act, logic [5:0] row, logic [5:0] col,
                           logic [7:0] pix);
            region_result_t e;
            int ar, ac;
            bit rim;
            e = '{default: '0};
            case (act)
                ACT_WRITE: begin
                    image[row*GRID + col] = pix;
                end
                ACT_FILL: begin
                    grow(int'(row), int'(col));
                    e.box_top = 6'(top);
                    e.box_left = 6'(left);
                    e.box_height = 7'(height);
                    e.box_width = 7'(width);
                    e.region_size = 13'(total);
                    pending = {pending, e};
                end
                ACT_READ: begin
                    if (total > 0 && int'(row) < height && int'(col) < width) begin
                        ar = top + int'(row);
                        ac = left + int'(col);
                        if (seen(ar, ac)) begin
                            rim = 1'b0;
                            for (int k = 0; k < 8; k++)
                                if (!seen(ar + dr[k], ac + dc[k])) rim = 1'b1;
                            e.region_value = fill_val;
                            e.in_region = 1'b1;
                            if (rim) begin
                                e.boundary_value = fill_val;
                                e.on_boundary = 1'b1;
                            end
                        end
                    end
                    pending = {pending, e};
                end
                default: ;
            endcase
        endfunction

        function void cmp(string name, int exp_v, int got_v);
            if (exp_v != got_v) begin
                errors++;
                $display("%0t %s expected %0d actual %0d", $time, name, exp_v, got_v);
            end
        endfunction

        function void check(region_result_t got);
            region_result_t e;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t unexpected result transaction, box %0d,%0d size %0d",
                         $time, got.box_top, got.box_left, got.region_size);
                return;
            end
            e = pending.pop_front();
            cmp("box_top", int'(e.box_top), int'(got.box_top));
            cmp("box_left", int'(e.box_left), int'(got.box_left));
            cmp("box_height", int'(e.box_height), int'(got.box_height));
            cmp("box_width", int'(e.box_width), int'(got.box_width));
            cmp("region_size", int'(e.region_size), int'(got.region_size));
            cmp("region_value", int'(e.region_value), int'(got.region_value));
            cmp("boundary_value", int'(e.boundary_value), int'(got.boundary_value));
            cmp("in_region", int'(e.in_region), int'(got.in_region));
            cmp("on_boundary", int'(e.on_boundary), int'(got.on_boundary));
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_action;
    logic [5:0]  i_row;
    logic [5:0]  i_col;
    logic [7:0]  i_pixel;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [6:0]  i_cfg_data;
    logic        o_valid;
    logic [5:0]  o_box_top;
    logic [5:0]  o_box_left;
    logic [6:0]  o_box_height;
    logic [6:0]  o_box_width;
    logic [12:0] o_region_size;
    logic [7:0]  o_region_value;
    logic [7:0]  o_boundary_value;
    logic        o_in_region;
    logic        o_on_boundary;

    region_scoreboard sb = new();
    int cycles;

    seeded_region_fill_boundary dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_action         (i_action),
        .i_row            (i_row),
        .i_col            (i_col),
        .i_pixel          (i_pixel),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .o_valid          (o_valid),
        .o_box_top        (o_box_top),
        .o_box_left       (o_box_left),
        .o_box_height     (o_box_height),
        .o_box_width      (o_box_width),
        .o_region_size    (o_region_size),
        .o_region_value   (o_region_value),
        .o_boundary_value (o_boundary_value),
        .o_in_region      (o_in_region),
        .o_on_boundary    (o_on_boundary)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // watchdog on total run length
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("seeded_region_fill_boundary: mismatch");
            $finish;
        end
    end

    // every result transaction lasts one cycle, sampled at the closing edge
    always @(posedge i_clk) begin
        region_result_t got;
        if (i_rst_n && o_valid) begin
            got.box_top = o_box_top;
            got.box_left = o_box_left;
            got.box_height = o_box_height;
            got.box_width = o_box_width;
            got.region_size = o_region_size;
            got.region_value = o_region_value;
            got.boundary_value = o_boundary_value;
            got.in_region = o_in_region;
            got.on_boundary = o_on_boundary;
            sb.check(got);
        end
    end

    // present one command; start stays high on return so back-to-back works
    task automatic send(logic [1:0] act, logic [5:0] r, logic [5:0] c, logic [7:0] p);
        @(negedge i_clk);
        start <= 1'b1;
        i_action <= act;
        i_row <= r;
        i_col <= c;
        i_pixel <= p;
        do @(posedge i_clk); while (busy);
        sb.note(act, r, c, p);
    endtask

    // mostly no gap, some short ones, a few long ones
    task automatic idle_gap();
        int pick, n;
        pick = $urandom_range(99);
        if (pick < 55) n = 0;
        else if (pick < 90) n = $urandom_range(1, 3);
        else n = $urandom_range(10, 40);
        if (n > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    // hold off the sender until every expected result has come back
    task automatic drain();
        @(negedge i_clk);
        start <= 1'b0;
        while (sb.pending.size() > 0) @(posedge i_clk);
    endtask

    // register writes only once the block is idle
    task automatic cfg_write(logic [1:0] idx, logic [6:0] d);
        drain();
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= d;
        @(posedge i_clk);
        sb.set_reg(idx, d);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // few distinct values so that regions are interesting
    function automatic logic [7:0] pick_pixel();
        if ($urandom_range(19) == 0) return 8'($urandom_range(255));
        return 8'($urandom_range(2));
    endfunction

    // set up one setting and fill the whole area in use with known pixels
    task automatic new_setting(bit c, logic [6:0] rows, logic [6:0] cols);
        int nr, nc;
        cfg_write(CFG_CONN, 7'(c));
        cfg_write(CFG_ROWS, rows);
        cfg_write(CFG_COLS, cols);
        nr = sb.eff_dim(int'(rows));
        nc = sb.eff_dim(int'(cols));
        for (int r = 0; r < nr; r++)
            for (int k = 0; k < nc; k++) begin
                send(ACT_WRITE, 6'(r), 6'(k), pick_pixel());
                idle_gap();
            end
    endtask

    // random mix: writes, fills, reads, a few unknown actions
    task automatic random_items(int count);
        int pick, nr, nc;
        logic [5:0] r, c;
        nr = sb.eff_dim(sb.rows_reg);
        nc = sb.eff_dim(sb.cols_reg);
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 40) begin
                if ($urandom_range(4) == 0) begin
                    r = 6'($urandom_range(63));
                    c = 6'($urandom_range(63));
                end else begin
                    r = 6'($urandom_range(nr - 1));
                    c = 6'($urandom_range(nc - 1));
                end
                send(ACT_WRITE, r, c, pick_pixel());
            end else if (pick < 54) begin
                if ($urandom_range(7) == 0) begin
                    r = 6'($urandom_range(63));
                    c = 6'($urandom_range(63));
                end else begin
                    r = 6'($urandom_range(nr - 1));
                    c = 6'($urandom_range(nc - 1));
                end
                send(ACT_FILL, r, c, 8'($urandom_range(255)));
            end else if (pick < 97) begin
                if ($urandom_range(9) == 0 || sb.total == 0) begin
                    r = 6'($urandom_range(63));
                    c = 6'($urandom_range(63));
                end else begin
                    r = 6'($urandom_range(sb.height));
                    c = 6'($urandom_range(sb.width));
                end
                send(ACT_READ, r, c, 8'($urandom_range(255)));
            end else begin
                send(ACT_NONE, 6'($urandom_range(63)), 6'($urandom_range(63)),
                     8'($urandom_range(255)));
            end
            idle_gap();
            if (n == count / 2 && $urandom_range(1)) drain();
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_action = ACT_WRITE;
        i_row = '0;
        i_col = '0;
        i_pixel = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_CONN;
        i_cfg_data = '0;
        cycles = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: small 4x4 image, then the corner cases
        new_setting(1'b0, 7'd4, 7'd4);
        cfg_write(CFG_UNUSED, 7'h7f);
        send(ACT_READ, 6'd0, 6'd0, 8'd0);          // read with no region yet
        send(ACT_NONE, 6'd63, 6'd63, 8'hff);       // unknown action
        send(ACT_FILL, 6'd63, 6'd63, 8'd0);        // seed outside area in use
        send(ACT_FILL, 6'd4, 6'd0, 8'd0);          // seed just past the last row
        send(ACT_WRITE, 6'd63, 6'd63, 8'hff);      // stored beyond the area
        send(ACT_WRITE, 6'd1, 6'd1, 8'hff);
        send(ACT_WRITE, 6'd1, 6'd2, 8'hff);
        send(ACT_WRITE, 6'd2, 6'd1, 8'hff);
        send(ACT_FILL, 6'd1, 6'd1, 8'd0);
        send(ACT_READ, 6'd0, 6'd0, 8'd0);
        send(ACT_READ, 6'd1, 6'd1, 8'd0);          // hole of the l shape
        send(ACT_READ, 6'd63, 6'd63, 8'd0);        // far outside the box
        send(ACT_WRITE, 6'd1, 6'd1, 8'h00);        // image changes after the fill
        send(ACT_READ, 6'd0, 6'd0, 8'd0);
        send(ACT_FILL, 6'd0, 6'd0, 8'd0);
        send(ACT_READ, 6'd0, 6'd0, 8'd0);
        send(ACT_READ, 6'd3, 6'd3, 8'd0);
        random_items(20);

        // sweep of settings, extremes included
        new_setting(1'b1, 7'd4, 7'd4);
        random_items(20);
        new_setting(1'b1, 7'd64, 7'd1);
        send(ACT_FILL, 6'd63, 6'd0, 8'd0);
        random_items(20);
        new_setting(1'b0, 7'd1, 7'd64);
        random_items(20);
        new_setting(1'b1, 7'd0, 7'd0);             // zero acts as one
        random_items(10);
        new_setting(1'b0, 7'd8, 7'd8);
        random_items(20);
        new_setting(1'b1, 7'd8, 7'd8);
        drain();
        random_items(20);
        new_setting(1'b1, 7'd127, 7'd1);           // above the maximum acts as it
        random_items(15);
        new_setting(1'b0, 7'd1, 7'd127);
        random_items(15);
        new_setting(1'b1, 7'd6, 7'd5);
        random_items(25);

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("seeded_region_fill_boundary: match");
        end else begin
            $display("seeded_region_fill_boundary: mismatch");
        end
        $finish;
    end

endmodule
`default_nettype wire
